// ===== rtl/hsb_rgb_colour_converter_defines.svh =====
// ----------------------------------------------------------------------------
// HSB/RGB colour converter assertion macros
// Shared assertion wrappers for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef HSB_RGB_COLOUR_CONVERTER_DEFINES_SVH
`define HSB_RGB_COLOUR_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// HRC package
// Shared constants, types and fixed-point helpers of the colour converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hrc_pkg;

    localparam int unsigned IN_W   = 24;
    localparam int unsigned OUT_W  = 17;
    localparam int unsigned NUM_W  = 36;
    localparam int unsigned DEN_W  = 19;
    localparam int unsigned QUO_W  = 17;
    localparam int unsigned LANES  = 2;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic DIR_HSB2RGB = 1'b0;
    localparam logic DIR_RGB2HSB = 1'b1;

    // Data that travels next to the divider lanes.
    typedef struct packed {
        logic        dir;
        logic        zero_spread;
        logic [16:0] max_c;
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
    } hrc_side_t;

    // Rounded Q16 product, halves up. Both operands stay within 0..1.0.
    function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] p;
        p = 34'(a) * 34'(b) + 34'd32768;
        return p[32:16];
    endfunction

    // Clamp a signed Q7.16 value to 0..1.0.
    function automatic logic [16:0] clamp_unit(input logic signed [23:0] x);
        logic [16:0] r;
        if (x < 0)
        begin
            r = 17'd0;
        end
        else if (x > 24'sd65536)
        begin
            r = ONE_Q16;
        end
        else
        begin
            r = x[16:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hrc_in_if.sv =====
// ----------------------------------------------------------------------------
// HRC input channel
// Valid/ready channel carrying one pixel of three signed Q7.16 components.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrc_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] first_component;
    logic signed [23:0] second_component;
    logic signed [23:0] third_component;

    modport source (output valid, first_component, second_component, third_component,
                    input ready);
    modport sink   (input valid, first_component, second_component, third_component,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hrc_out_if.sv =====
// ----------------------------------------------------------------------------
// HRC output channel
// Valid/ready channel carrying one converted pixel of three 17-bit results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrc_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] first_result;
    logic [16:0] second_result;
    logic [16:0] third_result;

    modport source (output valid, first_result, second_result, third_result,
                    input ready);
    modport sink   (input valid, first_result, second_result, third_result,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hrc_front.sv =====
// ----------------------------------------------------------------------------
// HRC front end
// Three stages: clamp, products and channel ordering, then RGB results and
// the divider operands for the RGB to HSB direction.
// ----------------------------------------------------------------------------
`default_nettype none

module hrc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                dir,
    input  wire logic                in_valid,
    input  wire logic signed [23:0]  comp_a,
    input  wire logic signed [23:0]  comp_b,
    input  wire logic signed [23:0]  comp_c,
    output logic                     out_valid,
    output logic [hrc_pkg::NUM_W-1:0] num0,
    output logic [hrc_pkg::DEN_W-1:0] den0,
    output logic [hrc_pkg::NUM_W-1:0] num1,
    output logic [hrc_pkg::DEN_W-1:0] den1,
    output hrc_pkg::hrc_side_t       side
);
    import hrc_pkg::*;

    // Stage 1 registers.
    logic        s1_valid_reg;
    logic        s1_dir_reg;
    logic [16:0] s1_a_reg, s1_b_reg, s1_c_reg;

    // Stage 2 registers.
    logic        s2_valid_reg;
    logic        s2_dir_reg;
    logic        s2_vzero_reg, s2_szero_reg;
    logic [2:0]  s2_dom_reg;
    logic [16:0] s2_v_reg, s2_p2_reg, s2_p3_reg, s2_f1_reg;
    logic [16:0] s2_mx_reg, s2_d_reg;
    logic [18:0] s2_n_reg;

    // Stage 3 registers.
    logic        s3_valid_reg;
    logic [NUM_W-1:0] num0_reg, num1_reg;
    logic [DEN_W-1:0] den0_reg, den1_reg;
    hrc_side_t   side_reg;

    // Stage 2 logic.
    logic [18:0] hd;
    logic [16:0] fr;
    logic [16:0] mx, mn, d;
    logic [19:0] d6;
    logic signed [20:0] n_raw, n_wrap;

    always_comb
    begin
        hd = 19'({s1_a_reg[15:0], 2'b00}) + 19'({s1_a_reg[15:0], 1'b0});
        fr = {1'b0, hd[15:0]};

        mx = s1_a_reg;
        if (s1_b_reg > mx)
        begin
            mx = s1_b_reg;
        end
        if (s1_c_reg > mx)
        begin
            mx = s1_c_reg;
        end
        mn = s1_a_reg;
        if (s1_b_reg < mn)
        begin
            mn = s1_b_reg;
        end
        if (s1_c_reg < mn)
        begin
            mn = s1_c_reg;
        end
        d  = mx - mn;
        d6 = 20'({d, 2'b00}) + 20'({d, 1'b0});

        priority if (s1_a_reg == mx)
        begin
            n_raw = 21'(s1_b_reg) - 21'(s1_c_reg);
        end
        else if (s1_b_reg == mx)
        begin
            n_raw = 21'({d, 1'b0}) + 21'(s1_c_reg) - 21'(s1_a_reg);
        end
        else
        begin
            n_raw = 21'({d, 2'b00}) + 21'(s1_a_reg) - 21'(s1_b_reg);
        end
        n_wrap = (n_raw < 0) ? n_raw + 21'(d6) : n_raw;
    end

    // Stage 3 logic.
    logic [16:0] f2, f3;
    logic [16:0] r_c, g_c, b_c;

    always_comb
    begin
        f2 = qmul(s2_v_reg, ONE_Q16 - s2_p2_reg);
        f3 = qmul(s2_v_reg, ONE_Q16 - s2_p3_reg);
        unique case (s2_dom_reg)
            3'd0:    begin r_c = s2_v_reg;  g_c = f3;        b_c = s2_f1_reg; end
            3'd1:    begin r_c = f2;        g_c = s2_v_reg;  b_c = s2_f1_reg; end
            3'd2:    begin r_c = s2_f1_reg; g_c = s2_v_reg;  b_c = f3;        end
            3'd3:    begin r_c = s2_f1_reg; g_c = f2;        b_c = s2_v_reg;  end
            3'd4:    begin r_c = f3;        g_c = s2_f1_reg; b_c = s2_v_reg;  end
            default: begin r_c = s2_v_reg;  g_c = s2_f1_reg; b_c = f2;        end
        endcase
        if (s2_vzero_reg)
        begin
            r_c = '0;
            g_c = '0;
            b_c = '0;
        end
        else if (s2_szero_reg)
        begin
            r_c = s2_v_reg;
            g_c = s2_v_reg;
            b_c = s2_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dir_reg <= dir;
            s1_a_reg   <= (dir == DIR_RGB2HSB) ? clamp_unit(comp_a) : {1'b0, comp_a[15:0]};
            s1_b_reg   <= clamp_unit(comp_b);
            s1_c_reg   <= clamp_unit(comp_c);

            s2_dir_reg   <= s1_dir_reg;
            s2_vzero_reg <= (s1_c_reg == 17'd0);
            s2_szero_reg <= (s1_b_reg == 17'd0);
            s2_dom_reg   <= hd[18:16];
            s2_v_reg     <= s1_c_reg;
            s2_p2_reg    <= qmul(s1_b_reg, fr);
            s2_p3_reg    <= qmul(s1_b_reg, ONE_Q16 - fr);
            s2_f1_reg    <= qmul(s1_c_reg, ONE_Q16 - s1_b_reg);
            s2_mx_reg    <= mx;
            s2_d_reg     <= d;
            s2_n_reg     <= n_wrap[18:0];

            num0_reg <= {3'b000, s2_d_reg, 16'd0} + NUM_W'(s2_mx_reg[16:1]);
            den0_reg <= DEN_W'(s2_mx_reg);
            num1_reg <= {1'b0, s2_n_reg, 16'd0} + NUM_W'({s2_d_reg, 1'b0})
                        + NUM_W'(s2_d_reg);
            den1_reg <= DEN_W'({s2_d_reg, 2'b00}) + DEN_W'({s2_d_reg, 1'b0});
            side_reg.dir         <= s2_dir_reg;
            side_reg.zero_spread <= (s2_d_reg == 17'd0);
            side_reg.max_c       <= s2_mx_reg;
            side_reg.red         <= r_c;
            side_reg.green       <= g_c;
            side_reg.blue        <= b_c;
        end
    end

    assign out_valid = s3_valid_reg;
    assign num0      = num0_reg;
    assign den0      = den0_reg;
    assign num1      = num1_reg;
    assign den1      = den1_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

// ===== rtl/hrc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// HRC divider pipeline
// Two restoring divider lanes, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module hrc_div_pipe (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [hrc_pkg::NUM_W-1:0]  num0,
    input  wire logic [hrc_pkg::DEN_W-1:0]  den0,
    input  wire logic [hrc_pkg::NUM_W-1:0]  num1,
    input  wire logic [hrc_pkg::DEN_W-1:0]  den1,
    input  wire hrc_pkg::hrc_side_t         side_in,
    output logic                            out_valid,
    output logic [hrc_pkg::QUO_W-1:0]       quo0,
    output logic [hrc_pkg::QUO_W-1:0]       quo1,
    output hrc_pkg::hrc_side_t              side_out
);
    import hrc_pkg::*;

    logic [QUO_W-1:0] valid_reg;
    logic [NUM_W-1:0] num_reg  [QUO_W][LANES];
    logic [DEN_W-1:0] den_reg  [QUO_W][LANES];
    logic [DEN_W-1:0] rem_reg  [QUO_W][LANES];
    logic [QUO_W-1:0] quo_reg  [QUO_W][LANES];
    hrc_side_t        side_reg [QUO_W];

    logic [NUM_W-1:0] num_in [LANES];
    logic [DEN_W-1:0] den_in [LANES];

    // One restoring step: shift in a numerator bit, subtract when it fits.
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                 input logic             nbit,
                                                 input logic [DEN_W-1:0] den);
        logic [DEN_W:0] rsh;
        logic [DEN_W:0] res;
        rsh = {rem, nbit};
        if (rsh >= {1'b0, den})
        begin
            res = {1'b1, DEN_W'(rsh - {1'b0, den})};
        end
        else
        begin
            res = {1'b0, rsh[DEN_W-1:0]};
        end
        return res;
    endfunction

    always_comb
    begin
        num_in[0] = num0;
        num_in[1] = num1;
        den_in[0] = den0;
        den_in[1] = den1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [DEN_W:0] st;
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int l = 0; l < LANES; l++)
            begin
                st = div_step(num_in[l][NUM_W-1:QUO_W], num_in[l][QUO_W-1], den_in[l]);
                num_reg[0][l] <= num_in[l];
                den_reg[0][l] <= den_in[l];
                rem_reg[0][l] <= st[DEN_W-1:0];
                quo_reg[0][l] <= {{(QUO_W-1){1'b0}}, st[DEN_W]};
            end
            for (int k = 1; k < QUO_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    st = div_step(rem_reg[k-1][l], num_reg[k-1][l][QUO_W-1-k],
                                  den_reg[k-1][l]);
                    num_reg[k][l] <= num_reg[k-1][l];
                    den_reg[k][l] <= den_reg[k-1][l];
                    rem_reg[k][l] <= st[DEN_W-1:0];
                    quo_reg[k][l] <= {quo_reg[k-1][l][QUO_W-2:0], st[DEN_W]};
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo0      = quo_reg[QUO_W-1][0];
    assign quo1      = quo_reg[QUO_W-1][1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/hsb_rgb_colour_converter.sv =====
// ----------------------------------------------------------------------------
// HSB/RGB colour converter
// Per-pixel conversion between hue/saturation/brightness and RGB in Q16.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Beat contents
//   pix_in    in   first/second/third_component, signed Q7.16
//   pix_out   out  first/second/third_result, unsigned, 65536 = 1.0
//   cfg       in   cfg_we / cfg_wdata, direction bit
//
// While the output is not stalled, one beat is accepted per cycle and one
// result beat leaves per cycle. There are three front stages, then seventeen
// divider stages of one quotient bit each; the last is the output register.
// Reset clears every valid bit and sets the direction to HSB to RGB.
// A stall at the output freezes the whole pipeline, so nothing is lost or
// repeated; while the output holds a waiting beat, bubbles in front move on
// only when the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsb_rgb_colour_converter_defines.svh"

module hsb_rgb_colour_converter (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    hrc_in_if.sink    pix_in,
    hrc_out_if.source pix_out
);
    import hrc_pkg::*;

    logic dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_HSB2RGB;
        end
        else if (cfg_we)
        begin
            dir_reg <= cfg_wdata;
        end
    end

    // The pipeline advances whenever the output register is empty or taken.
    logic en;
    logic front_valid, div_valid;
    logic [NUM_W-1:0] num0, num1;
    logic [DEN_W-1:0] den0, den1;
    logic [QUO_W-1:0] quo0, quo1;
    hrc_side_t front_side, div_side;

    assign en           = !div_valid || pix_out.ready;
    assign pix_in.ready = en;

    hrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .dir       (dir_reg),
        .in_valid  (pix_in.valid),
        .comp_a    (pix_in.first_component),
        .comp_b    (pix_in.second_component),
        .comp_c    (pix_in.third_component),
        .out_valid (front_valid),
        .num0      (num0),
        .den0      (den0),
        .num1      (num1),
        .den1      (den1),
        .side      (front_side)
    );

    // Lane 0 gives saturation, lane 1 gives hue.
    hrc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num0      (num0),
        .den0      (den0),
        .num1      (num1),
        .den1      (den1),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quo0      (quo0),
        .quo1      (quo1),
        .side_out  (div_side)
    );

    // Output selection. A hue that rounds up to 1.0 wraps to zero, which is
    // just the low sixteen bits since the quotient never exceeds 1.0.
    always_comb
    begin
        pix_out.valid = div_valid;
        if (div_side.dir == DIR_RGB2HSB)
        begin
            if (div_side.zero_spread)
            begin
                pix_out.first_result  = '0;
                pix_out.second_result = '0;
            end
            else
            begin
                pix_out.first_result  = {1'b0, quo1[15:0]};
                pix_out.second_result = quo0;
            end
            pix_out.third_result = div_side.max_c;
        end
        else
        begin
            pix_out.first_result  = div_side.red;
            pix_out.second_result = div_side.green;
            pix_out.third_result  = div_side.blue;
        end
    end

    // Hue leaves below 1.0.
    `HRC_ASSERT_NOW(a_hue_wrapped, clk, rst_n,
        pix_out.valid && div_side.dir == DIR_RGB2HSB, pix_out.first_result[16] == 1'b0,
        "hue result reached 1.0")
    // Saturation never exceeds 1.0.
    `HRC_ASSERT_NOW(a_sat_range, clk, rst_n,
        pix_out.valid && div_side.dir == DIR_RGB2HSB, pix_out.second_result <= ONE_Q16,
        "saturation above 1.0")
    // A stalled result is kept and the input side is held off.
    `HRC_ASSERT_NEXT(a_stall_hold, clk, rst_n,
        pix_out.valid && !pix_out.ready, pix_out.valid && $stable(div_side),
        "stalled result lost")

endmodule

`default_nettype wire
